// File: rtl/pse_pkg.sv
// Shared constants and types for the postfix stack evaluator.
package pse_pkg;

  // Operand stack geometry
  localparam int unsigned StackDepth = 1024;
  localparam int unsigned AddrW      = $clog2(StackDepth);
  localparam int unsigned PtrW       = $clog2(StackDepth + 1);
  localparam int unsigned DataW      = 32;
  localparam int unsigned DepthW     = 11;
  localparam int unsigned CntW       = $clog2(DataW);

  // Character codes
  localparam logic [7:0] SymPlus  = 8'h2B;
  localparam logic [7:0] SymMinus = 8'h2D;
  localparam logic [7:0] SymStar  = 8'h2A;
  localparam logic [7:0] SymSlash = 8'h2F;
  localparam logic [7:0] SymSpace = 8'h20;
  localparam logic [DataW-1:0] ZeroCode = 32'd48;

  // Status codes
  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StUnderflow = 2'd1;
  localparam logic [1:0] StDivZero   = 2'd2;
  localparam logic [1:0] StFull      = 2'd3;

  // Decoded kind of one character
  typedef enum logic [2:0] {
    OpAdd,
    OpSub,
    OpMul,
    OpDiv,
    OpPush,
    OpNone
  } op_e;

  // Decode a character into its operation
  function automatic op_e decode_sym(input logic [7:0] sym);
    op_e op;
    case (sym)
      SymPlus:  op = OpAdd;
      SymMinus: op = OpSub;
      SymStar:  op = OpMul;
      SymSlash: op = OpDiv;
      SymSpace: op = OpNone;
      default:  op = OpPush;
    endcase
    return op;
  endfunction

endpackage

// File: rtl/pse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pse_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/postfix_stack_evaluator_unit.sv
// Postfix evaluator: operand stack in RAM and a bit-serial arithmetic unit.
//
// Input stream: one character word per transfer, tdata[7:0] = symbol and
// tlast = end of expression. '+', '-', '*' and '/' pop two operands and
// push the result; a space does nothing; any other code pushes code - 48.
// Output stream: one word per input word, tdata[31:0] = top of stack,
// tdata[42:32] = depth, tdata[44:43] = status, tlast = expression done.
// Sequence: an operand or space goes from accept through the write-back
// state into the output register; an operator goes through a RAM read
// state, the serial loop of the shared add/multiply/divide datapath, the
// write-back state and then the output register. One word is in flight at
// a time: a new word is accepted only after the last one is written back.
// The result sits in an output register; the next input word is accepted
// while it waits. If the output stays stalled, the following word waits in
// its write-back cycle until the register frees up.
// Reset empties the stack (pointer to zero) and drops any pending output.
// The stack memory needs no clearing: only written entries are ever read.
module postfix_stack_evaluator_unit
  import pse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: symbol[7:0]
  input  logic [7:0]  s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: top_value[31:0], stack_depth[42:32], status[44:43], zero[47:45]
  output logic [47:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLoad = 2'd1;
  localparam logic [1:0] StExec = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [PtrW-1:0]  sp_q, sp_d;
  logic [DataW-1:0] top_q, top_d;
  logic [7:0]       sym_q;
  logic             last_q;
  op_e              op_q;
  logic [DataW-1:0] a_q, a_d;
  logic [DataW-1:0] b_q, b_d;
  logic [DataW-1:0] acc_q, acc_d;
  logic             carry_q, carry_d;
  logic             neg_q, neg_d;
  logic [1:0]       stat_q, stat_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  logic [DataW-1:0]  out_top_q;
  logic [DepthW-1:0] out_depth_q;
  logic [1:0]        out_stat_q;
  logic              out_last_q;
  logic              out_valid_q;

  logic             in_fire;
  logic             out_free;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [DataW-1:0] ram_wdata;
  logic [AddrW-1:0] ram_raddr;
  logic [DataW-1:0] ram_rdata;

  logic [DataW-1:0] first_val, second_val;
  logic             sum_bit, sum_carry;
  logic [DataW-1:0] div_shift;
  logic [DataW:0]   div_diff;
  logic [DataW-1:0] op_result;
  logic [PtrW-1:0]  fin_sp;
  logic [DataW-1:0] fin_top;
  logic [1:0]       fin_stat;

  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == StIdle);
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Operand stack storage
  pse_ram #(
    .Width (DataW),
    .Depth (StackDepth)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Second operand lives two below the pointer
  assign ram_raddr = AddrW'(sp_q - PtrW'(2));

  // Popped values, with -1 standing in for an empty slot
  assign first_val  = (sp_q != '0) ? top_q : '1;
  assign second_val = (sp_q >= PtrW'(2)) ? ram_rdata : '1;

  // Serial full adder, one bit per cycle
  assign sum_bit   = a_q[0] ^ b_q[0] ^ carry_q;
  assign sum_carry = (a_q[0] & b_q[0]) | (carry_q & (a_q[0] ^ b_q[0]));

  // Restoring division step
  assign div_shift = {acc_q[DataW-2:0], a_q[DataW-1]};
  assign div_diff  = {1'b0, div_shift} - {1'b0, b_q};

  // Final operator result
  always_comb begin
    case (op_q)
      OpDiv:   op_result = (stat_q == StDivZero) ? '0 : (neg_q ? ('0 - a_q) : a_q);
      default: op_result = acc_q;
    endcase
  end

  // Write-back: new pointer, top and status
  always_comb begin
    fin_sp    = sp_q;
    fin_top   = top_q;
    fin_stat  = stat_q;
    ram_we    = 1'b0;
    ram_waddr = sp_q[AddrW-1:0];
    ram_wdata = op_result;
    case (op_q)
      OpAdd, OpSub, OpMul, OpDiv: begin
        fin_sp    = (sp_q >= PtrW'(2)) ? (sp_q - PtrW'(1)) : PtrW'(1);
        fin_top   = op_result;
        ram_we    = (state_q == StFin) && out_free;
        ram_waddr = AddrW'(fin_sp - PtrW'(1));
      end
      OpPush: begin
        ram_wdata = {24'b0, sym_q} - ZeroCode;
        if (sp_q == PtrW'(StackDepth)) begin
          fin_stat = StFull;
        end else begin
          fin_sp  = sp_q + PtrW'(1);
          fin_top = ram_wdata;
          ram_we  = (state_q == StFin) && out_free;
        end
      end
      default: ;
    endcase
  end

  // Sequencer and datapath
  always_comb begin
    state_d = state_q;
    sp_d    = sp_q;
    top_d   = top_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    carry_d = carry_q;
    neg_d   = neg_q;
    stat_d  = stat_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          state_d = (decode_sym(s_axis_tdata_i) inside {OpPush, OpNone}) ? StFin : StLoad;
          stat_d  = StOk;
        end
      end
      StLoad: begin
        cnt_d   = '0;
        acc_d   = '0;
        carry_d = 1'b0;
        neg_d   = 1'b0;
        a_d     = second_val;
        b_d     = first_val;
        stat_d  = (sp_q < PtrW'(2)) ? StUnderflow : StOk;
        case (op_q)
          OpSub: begin
            b_d     = ~first_val;
            carry_d = 1'b1;
          end
          OpDiv: begin
            a_d   = second_val[DataW-1] ? ('0 - second_val) : second_val;
            b_d   = first_val[DataW-1] ? ('0 - first_val) : first_val;
            neg_d = second_val[DataW-1] ^ first_val[DataW-1];
            if (first_val == '0) begin
              stat_d = StDivZero;
            end
          end
          default: ;
        endcase
        state_d = StExec;
      end
      StExec: begin
        cnt_d = cnt_q + CntW'(1);
        case (op_q)
          OpMul: begin
            acc_d = acc_q + (b_q[0] ? a_q : '0);
            a_d   = {a_q[DataW-2:0], 1'b0};
            b_d   = {1'b0, b_q[DataW-1:1]};
          end
          OpDiv: begin
            if (!div_diff[DataW]) begin
              acc_d = div_diff[DataW-1:0];
            end else begin
              acc_d = div_shift;
            end
            a_d = {a_q[DataW-2:0], !div_diff[DataW]};
          end
          default: begin
            acc_d   = {sum_bit, acc_q[DataW-1:1]};
            carry_d = sum_carry;
            a_d     = {1'b0, a_q[DataW-1:1]};
            b_d     = {1'b0, b_q[DataW-1:1]};
          end
        endcase
        if (cnt_q == CntW'(DataW - 1)) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          sp_d    = last_q ? '0 : fin_sp;
          top_d   = fin_top;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      if (state_q == StFin && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    top_q   <= top_d;
    a_q     <= a_d;
    b_q     <= b_d;
    acc_q   <= acc_d;
    carry_q <= carry_d;
    neg_q   <= neg_d;
    stat_q  <= stat_d;
    cnt_q   <= cnt_d;
    if (in_fire) begin
      sym_q  <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
      op_q   <= decode_sym(s_axis_tdata_i);
    end
    if (state_q == StFin && out_free) begin
      out_top_q   <= (fin_sp != '0) ? fin_top : '0;
      out_depth_q <= DepthW'(fin_sp);
      out_stat_q  <= fin_stat;
      out_last_q  <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_stat_q, out_depth_q, out_top_q};
  assign m_axis_tlast_o  = out_last_q;

  // Pointer never passes the stack size
  assert property (@(posedge clk_i) disable iff (!rst_ni) sp_q <= PtrW'(StackDepth))
    else $error("stack pointer beyond stack size");

  // One word at a time: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> !s_axis_tready_o)
    else $error("second word accepted while busy");

  // Serial unit only runs for operators
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StExec) |-> (op_q != OpPush && op_q != OpNone))
    else $error("serial unit running for a non-operator");

  // Write-back leaves a valid result in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && out_free) |=> m_axis_tvalid_o)
    else $error("result lost at write-back");

endmodule

// File: sim/postfix_stack_evaluator_unit_test.sv
// Self-checking stream testbench for the postfix stack evaluator.
`timescale 1ns / 1ps

module postfix_stack_evaluator_unit_test
  import pse_pkg::*;
;

  // One character word on the input side
  typedef struct packed {
    logic [7:0] sym;
    logic       last;
  } char_t;

  // One result word on the output side
  typedef struct packed {
    logic [DataW-1:0]  top;
    logic [DepthW-1:0] depth;
    logic [1:0]        status;
    logic              done;
  } result_t;

  localparam int unsigned LongHoldStart  = 200;
  localparam int unsigned LongHoldCycles = 400;
  localparam int unsigned DrainCycles    = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;

  // Characters waiting to be sent and results still due
  char_t   chars_q[$];
  result_t results_due_q[$];
  char_t   next_char;

  // Shadow copy of the operand stack
  logic [DataW-1:0] operand_mem [StackDepth];
  int unsigned      stack_ptr = 0;

  int unsigned sender_idle_pct = 13;
  int unsigned recv_idle_pct   = 50;
  int unsigned hold_left       = 0;
  logic        long_hold_done  = 1'b0;

  int unsigned words_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count  = 0;
  int unsigned operator_count  = 0;
  int unsigned underflow_count = 0;
  int unsigned divzero_count   = 0;
  int unsigned full_count      = 0;

  postfix_stack_evaluator_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tlast_i  (s_axis_tlast),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Pop one operand; an empty stack yields all ones and flags underflow
  function automatic logic [DataW-1:0] pop_operand(inout logic [1:0] st);
    if (stack_ptr == 0) begin
      if (st == StOk) st = StUnderflow;
      return '1;
    end
    stack_ptr--;
    return operand_mem[stack_ptr];
  endfunction

  // Push one operand; drop it and flag when the stack is full
  function automatic void push_operand(input logic [DataW-1:0] v, inout logic [1:0] st);
    if (stack_ptr >= StackDepth) begin
      st = StFull;
      return;
    end
    operand_mem[stack_ptr] = v;
    stack_ptr++;
  endfunction

  // Work out the result word that one accepted character causes
  task automatic evaluate_char(input char_t c);
    op_e              op;
    logic [DataW-1:0] first, second, r, un, ud, q;
    logic [1:0]       st;
    result_t          res;
    st = StOk;
    case (c.sym)
      SymPlus:  op = OpAdd;
      SymMinus: op = OpSub;
      SymStar:  op = OpMul;
      SymSlash: op = OpDiv;
      SymSpace: op = OpNone;
      default:  op = OpPush;
    endcase
    if (op == OpPush) begin
      push_operand({24'd0, c.sym} - ZeroCode, st);
    end else if (op != OpNone) begin
      operator_count++;
      first  = pop_operand(st);
      second = pop_operand(st);
      case (op)
        OpAdd:   r = second + first;
        OpSub:   r = second - first;
        OpMul:   r = second * first;
        default: begin
          if (first == '0) begin
            r  = '0;
            st = StDivZero;
          end else begin
            // Divide magnitudes, then restore the sign; truncates toward zero
            un = second[DataW-1] ? -second : second;
            ud = first[DataW-1] ? -first : first;
            q  = un / ud;
            r  = (second[DataW-1] ^ first[DataW-1]) ? -q : q;
          end
        end
      endcase
      push_operand(r, st);
    end
    case (st)
      StUnderflow: underflow_count++;
      StDivZero:   divzero_count++;
      StFull:      full_count++;
      default:     ;
    endcase
    res.top    = (stack_ptr != 0) ? operand_mem[stack_ptr-1] : '0;
    res.depth  = stack_ptr[DepthW-1:0];
    res.status = st;
    res.done   = c.last;
    results_due_q.push_back(res);
    if (c.last) stack_ptr = 0;
  endtask

  // Driver: present queued characters, idling at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'h00;
      s_axis_tlast  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        evaluate_char('{sym: s_axis_tdata, last: s_axis_tlast});
        words_sent <= words_sent + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (chars_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_char = chars_q.pop_front();
          s_axis_tdata  <= next_char.sym;
          s_axis_tlast  <= next_char.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, hold off once for a long stretch, check words
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      m_axis_tready  <= 1'b0;
      hold_left      <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected word: expected none, actual %h last %b",
                   $realtime, m_axis_tdata, m_axis_tlast);
        end else begin
          want = results_due_q.pop_front();
          results_checked++;
          if (m_axis_tdata[31:0] !== want.top) begin
            mismatch_count++;
            $display("%0t: top_value mismatch: expected %0d, actual %0d", $realtime,
                     $signed(want.top), $signed(m_axis_tdata[31:0]));
          end
          if (m_axis_tdata[42:32] !== want.depth) begin
            mismatch_count++;
            $display("%0t: stack_depth mismatch: expected %0d, actual %0d", $realtime,
                     want.depth, m_axis_tdata[42:32]);
          end
          if (m_axis_tdata[44:43] !== want.status) begin
            mismatch_count++;
            $display("%0t: status mismatch: expected %0d, actual %0d", $realtime,
                     want.status, m_axis_tdata[44:43]);
          end
          if (m_axis_tlast !== want.done) begin
            mismatch_count++;
            $display("%0t: expression_done mismatch: expected %b, actual %b", $realtime,
                     want.done, m_axis_tlast);
          end
        end
      end
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && words_sent >= LongHoldStart) begin
        hold_left      <= LongHoldCycles;
        long_hold_done <= 1'b1;
        m_axis_tready  <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic add_char(input logic [7:0] sym, input logic last);
    chars_q.push_back('{sym: sym, last: last});
  endtask

  // Any code that pushes: neither an operator nor a space
  function automatic logic [7:0] random_operand_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (b == SymPlus || b == SymMinus || b == SymStar || b == SymSlash ||
               b == SymSpace);
    return b;
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(3))
      0:       return SymPlus;
      1:       return SymMinus;
      2:       return SymStar;
      default: return SymSlash;
    endcase
  endfunction

  // Mostly well-formed expressions with random content, some noise and
  // some expressions left unbalanced
  task automatic gen_random(input int unsigned quota);
    logic [7:0]  expr_q[$];
    int unsigned made, steps, depth_now;
    made = 0;
    while (made < quota) begin
      if ($urandom_range(99) < 15) begin
        add_char(8'($urandom_range(255)), $urandom_range(7) == 0);
        made++;
      end else begin
        expr_q.delete();
        depth_now = 0;
        steps = $urandom_range(12, 1);
        repeat (steps) begin
          if ($urandom_range(9) == 0) expr_q.push_back(SymSpace);
          if (depth_now < 2 || $urandom_range(1) == 0) begin
            if ($urandom_range(9) < 7)
              expr_q.push_back(ZeroCode[7:0] + 8'($urandom_range(9)));
            else expr_q.push_back(random_operand_byte());
            depth_now++;
          end else begin
            expr_q.push_back(pick_operator());
            depth_now--;
          end
        end
        if ($urandom_range(9) != 0) begin
          while (depth_now > 1) begin
            expr_q.push_back(pick_operator());
            depth_now--;
          end
        end else begin
          expr_q.push_back(pick_operator());
        end
        foreach (expr_q[i]) begin
          add_char(expr_q[i], i == expr_q.size() - 1);
          if (expr_q[i] != SymSpace) made++;
        end
      end
    end
  endtask

  // Wait until every queued character has gone and every result has come
  task automatic wait_for_drain();
    while (chars_q.size() != 0 || s_axis_tvalid || results_due_q.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Extreme codes, space, operator after an empty stack, wrap on multiply
    add_char(8'h00, 1'b0);
    add_char(8'hFF, 1'b0);
    add_char(SymStar, 1'b0);
    add_char(SymSpace, 1'b0);
    add_char(SymMinus, 1'b1);
    add_char(SymPlus, 1'b1);
    // Divide by zero wins over underflow in the same character
    add_char(ZeroCode[7:0], 1'b0);
    add_char(SymSlash, 1'b1);
    // Most negative value divided by minus one
    repeat (4) add_char(8'd176, 1'b0);
    repeat (3) add_char(SymStar, 1'b0);
    add_char(ZeroCode[7:0] + 8'd8, 1'b0);
    add_char(SymStar, 1'b0);
    add_char(ZeroCode[7:0], 1'b0);
    add_char(ZeroCode[7:0] + 8'd1, 1'b0);
    add_char(SymMinus, 1'b0);
    add_char(SymSlash, 1'b1);
    // Negative quotient truncates toward zero; expression ends on a space
    add_char(ZeroCode[7:0], 1'b0);
    add_char(ZeroCode[7:0] + 8'd7, 1'b0);
    add_char(SymMinus, 1'b0);
    add_char(ZeroCode[7:0] + 8'd2, 1'b0);
    add_char(SymSlash, 1'b0);
    add_char(SymSpace, 1'b1);
    wait_for_drain();

    // Fill the stack, push onto a full stack, free one slot, fill again
    repeat (StackDepth) add_char(random_operand_byte(), 1'b0);
    add_char(random_operand_byte(), 1'b0);
    add_char(SymPlus, 1'b0);
    add_char(random_operand_byte(), 1'b0);
    add_char(random_operand_byte(), 1'b1);
    wait_for_drain();

    gen_random(180);
    wait_for_drain();

    sender_idle_pct = 50;
    recv_idle_pct   = 13;
    gen_random(180);
    wait_for_drain();

    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    gen_random(190);
    wait_for_drain();

    repeat (DrainCycles) @(negedge clk_i);
    $display("Sent %0d characters (%0d operators), checked %0d results.",
             words_sent, operator_count, results_checked);
    $display("Saw %0d underflows, %0d divisions by zero, %0d pushes onto a full stack.",
             underflow_count, divzero_count, full_count);
    if (mismatch_count == 0 && results_due_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// File: filelist.f
rtl/pse_pkg.sv
rtl/pse_ram.sv
rtl/postfix_stack_evaluator_unit.sv
sim/postfix_stack_evaluator_unit_test.sv
